>>> rtl/gksp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gksp_pkg
// Shared types and constants of the grid kick shortest-path block.
// ----------------------------------------------------------------------------
package gksp_pkg;

    localparam int COST_W     = 10;
    localparam logic [COST_W-1:0] COST_NONE = '1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 6;
    localparam int DIM_CFG_W  = 6;
    localparam int POS_CFG_W  = 5;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_ROW = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_COL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GOAL_ROW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GOAL_COL  = 3'd5;

    // Moves out of one cell: four free steps, then eight kick landings
    localparam int NUM_TGT  = 12;
    localparam int NUM_ZERO = 4;
    localparam int TGT_W    = 4;

    typedef logic signed [2:0] t_off;

    localparam t_off TGT_DR [NUM_TGT] = '{
        -3'sd1, 3'sd0, 3'sd1, 3'sd0,
        -3'sd1, -3'sd2, 3'sd0, 3'sd0, 3'sd1, 3'sd2, 3'sd0, 3'sd0
    };
    localparam t_off TGT_DC [NUM_TGT] = '{
        3'sd0, 3'sd1, 3'sd0, -3'sd1,
        3'sd0, 3'sd0, 3'sd1, 3'sd2, 3'sd0, 3'sd0, -3'sd1, -3'sd2
    };

    typedef struct packed {
        logic clear;
        logic push_front;
        logic push_back;
        logic pop;
    } t_dq_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_dq_stat;

endpackage

>>> rtl/gksp_grid_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gksp_grid_mem
// Wall map and best-cost store, one shared registered read address.
// ----------------------------------------------------------------------------
module gksp_grid_mem #(
    parameter int CELLS = 1024,
    parameter int AW    = 10
) (
    input  logic                       i_clk,
    input  logic                       i_wall_we,
    input  logic [AW-1:0]              i_wall_waddr,
    input  logic                       i_wall_wdata,
    input  logic                       i_cost_we,
    input  logic [AW-1:0]              i_cost_waddr,
    input  logic [gksp_pkg::COST_W-1:0] i_cost_wdata,
    input  logic [AW-1:0]              i_rd_addr,
    output logic                       o_wall,
    output logic [gksp_pkg::COST_W-1:0] o_cost
);
    import gksp_pkg::*;

    logic              wall_mem [CELLS];
    logic [COST_W-1:0] cost_mem [CELLS];

    always_ff @(posedge i_clk) begin
        if (i_wall_we) begin
            wall_mem[i_wall_waddr] <= i_wall_wdata;
        end
        o_wall <= wall_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cost_we) begin
            cost_mem[i_cost_waddr] <= i_cost_wdata;
        end
        o_cost <= cost_mem[i_rd_addr];
    end

endmodule

>>> rtl/gksp_deque.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gksp_deque
// Circular double-ended work queue; pushes into a full queue are dropped.
// ----------------------------------------------------------------------------
module gksp_deque #(
    parameter int DEPTH = 4096,
    parameter int EW    = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gksp_pkg::t_dq_cmd   i_cmd,
    input  logic [EW-1:0]       i_wdata,
    output logic [EW-1:0]       o_rdata,
    output gksp_pkg::t_dq_stat  o_stat
);
    import gksp_pkg::*;

    localparam int PW = $clog2(DEPTH);

    logic [EW-1:0] dq_mem [DEPTH];
    logic [PW-1:0] r_head, n_head, r_tail, n_tail;
    logic [PW:0]   r_cnt, n_cnt;
    logic [PW-1:0] head_inc, head_dec, tail_inc, wr_idx;
    logic          wr_en;

    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == (PW+1)'(DEPTH));

    assign head_inc = (r_head == PW'(DEPTH-1)) ? '0 : r_head + 1'b1;
    assign head_dec = (r_head == '0) ? PW'(DEPTH-1) : r_head - 1'b1;
    assign tail_inc = (r_tail == PW'(DEPTH-1)) ? '0 : r_tail + 1'b1;

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_cnt  = r_cnt;
        wr_en  = 1'b0;
        wr_idx = r_tail;
        if (i_cmd.clear) begin
            n_head = '0;
            n_tail = '0;
            n_cnt  = '0;
        end else if (i_cmd.push_front && !o_stat.full) begin
            n_head = head_dec;
            n_cnt  = r_cnt + 1'b1;
            wr_en  = 1'b1;
            wr_idx = head_dec;
        end else if (i_cmd.push_back && !o_stat.full) begin
            n_tail = tail_inc;
            n_cnt  = r_cnt + 1'b1;
            wr_en  = 1'b1;
        end else if (i_cmd.pop && !o_stat.empty) begin
            n_head = head_inc;
            n_cnt  = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_cnt  <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            dq_mem[wr_idx] <= i_wdata;
        end
        if (i_cmd.pop) begin
            o_rdata <= dq_mem[r_head];
        end
    end

endmodule

>>> rtl/grid_kick_shortest_path.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_kick_shortest_path
// Loads a wall/floor grid and returns the least kick count from start to goal.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one grid cell per
//   transaction in row-major order: i_is_wall, i_last_cell. Cells load at one
//   per cycle while o_in_stall is low; cells past the clamped grid size are ignored.
//   The transaction with i_last_cell high starts the search; o_in_stall stays
//   high until the result is placed in the output register.
//   Search: a clearing sweep over all MAX_ROWS*MAX_COLS cells sets every cost
//   to all ones, then each deque pop reads its cell and then each candidate
//   move (up to 12 moves) in turn, all paced by the single read port of the
//   grid memory.
//   Output channel (o_out_valid / i_out_stall) carries o_kick_count, held
//   stable while stalled; 1023 means the goal cannot be reached. The next
//   grid may load and be searched while a result waits; the new result waits for it.
//   Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_wdata
//   while the block is idle. Reset restores register defaults (32x32 grid,
//   start and goal at the origin) and empties the output.
// ----------------------------------------------------------------------------
module grid_kick_shortest_path #(
    parameter int MAX_ROWS    = 32,
    parameter int MAX_COLS    = 32,
    parameter int DEQUE_DEPTH = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_is_wall,
    input  logic                              i_last_cell,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [gksp_pkg::COST_W-1:0]       o_kick_count,
    input  logic                              i_cfg_we,
    input  logic [gksp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [gksp_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);
    import gksp_pkg::*;

    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(CELLS);
    localparam int LW    = $clog2(CELLS + 1);
    localparam int EW    = RW + CW;

    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_CLEAR = 4'd1;
    localparam logic [3:0] S_SEED  = 4'd2;
    localparam logic [3:0] S_POP   = 4'd3;
    localparam logic [3:0] S_CADR  = 4'd4;
    localparam logic [3:0] S_CEV   = 4'd5;
    localparam logic [3:0] S_TADR  = 4'd6;
    localparam logic [3:0] S_TEV   = 4'd7;
    localparam logic [3:0] S_GOAL  = 4'd8;
    localparam logic [3:0] S_GRD   = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    // Configuration registers
    logic [DIM_CFG_W-1:0] r_grid_rows, r_grid_cols;
    logic [POS_CFG_W-1:0] r_start_row, r_start_col, r_goal_row, r_goal_col;

    // Control
    logic [3:0]        r_state, n_state;
    logic [LW-1:0]     r_ld_idx;
    logic [AW-1:0]     r_clr;
    logic [RW-1:0]     r_cur_r, r_tr;
    logic [CW-1:0]     r_cur_c, r_tc;
    logic [COST_W-1:0] r_d;
    logic [TGT_W-1:0]  r_tgt;
    logic [AW-1:0]     r_taddr;
    logic              r_tin, r_gin;
    logic [COST_W-1:0] r_res;
    logic              r_out_valid;
    logic [COST_W-1:0] r_kick_count;

    // Derived sizes
    logic [RW:0]       eff_rows;
    logic [CW:0]       eff_cols;
    logic [RW+CW+1:0]  total;

    // Shared address multiplier
    logic [RW-1:0]     mul_r;
    logic [CW-1:0]     mul_c;
    logic [RW+CW+1:0]  lin_full;
    logic [AW-1:0]     lin;

    // Candidate move
    logic signed [RW+1:0] tr_s;
    logic signed [CW+1:0] tc_s;
    logic                 t_ok;

    logic start_ok, goal_ok;
    logic in_acc;

    // Memory and deque hookups
    logic              wall_we, cost_we, wall_rd;
    logic [AW-1:0]     cost_waddr, rd_addr;
    logic [COST_W-1:0] cost_wdata, cost_rd;
    t_dq_cmd           dq_cmd;
    t_dq_stat          dq_stat;
    logic [EW-1:0]     dq_wdata, dq_rdata;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_LOAD);
    assign o_out_valid  = r_out_valid;
    assign o_kick_count = r_kick_count;

    // Clamp grid size to 1..MAX
    always_comb begin
        if (r_grid_rows == '0) begin
            eff_rows = (RW+1)'(1);
        end else if (32'(r_grid_rows) > 32'(MAX_ROWS)) begin
            eff_rows = (RW+1)'(MAX_ROWS);
        end else begin
            eff_rows = (RW+1)'(r_grid_rows);
        end
        if (r_grid_cols == '0) begin
            eff_cols = (CW+1)'(1);
        end else if (32'(r_grid_cols) > 32'(MAX_COLS)) begin
            eff_cols = (CW+1)'(MAX_COLS);
        end else begin
            eff_cols = (CW+1)'(r_grid_cols);
        end
    end

    assign total    = eff_rows * eff_cols;
    assign start_ok = (32'(r_start_row) < 32'(eff_rows)) && (32'(r_start_col) < 32'(eff_cols));
    assign goal_ok  = (32'(r_goal_row) < 32'(eff_rows)) && (32'(r_goal_col) < 32'(eff_cols));

    // Neighbor of the current cell for the active move
    assign tr_s = $signed({2'b00, r_cur_r}) + (RW+2)'(TGT_DR[r_tgt]);
    assign tc_s = $signed({2'b00, r_cur_c}) + (CW+2)'(TGT_DC[r_tgt]);
    assign t_ok = !tr_s[RW+1] && (tr_s[RW:0] < eff_rows)
               && !tc_s[CW+1] && (tc_s[CW:0] < eff_cols);

    always_comb begin
        unique case (r_state)
            S_CADR: begin
                mul_r = dq_rdata[EW-1:CW];
                mul_c = dq_rdata[CW-1:0];
            end
            S_TADR: begin
                mul_r = tr_s[RW-1:0];
                mul_c = tc_s[CW-1:0];
            end
            S_SEED: begin
                mul_r = RW'(r_start_row);
                mul_c = CW'(r_start_col);
            end
            S_GOAL: begin
                mul_r = RW'(r_goal_row);
                mul_c = CW'(r_goal_col);
            end
            default: begin
                mul_r = r_cur_r;
                mul_c = r_cur_c;
            end
        endcase
    end

    assign lin_full = mul_r * eff_cols + (RW+CW+2)'(mul_c);
    assign lin      = AW'(lin_full);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= DIM_CFG_W'(32);
            r_grid_cols <= DIM_CFG_W'(32);
            r_start_row <= '0;
            r_start_col <= '0;
            r_goal_row  <= '0;
            r_goal_col  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_GRID_ROWS: r_grid_rows <= i_cfg_wdata;
                REG_GRID_COLS: r_grid_cols <= i_cfg_wdata;
                REG_START_ROW: r_start_row <= i_cfg_wdata[POS_CFG_W-1:0];
                REG_START_COL: r_start_col <= i_cfg_wdata[POS_CFG_W-1:0];
                REG_GOAL_ROW:  r_goal_row  <= i_cfg_wdata[POS_CFG_W-1:0];
                REG_GOAL_COL:  r_goal_col  <= i_cfg_wdata[POS_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Memory, deque and next-state control
    always_comb begin
        n_state    = r_state;
        wall_we    = 1'b0;
        cost_we    = 1'b0;
        cost_waddr = r_taddr;
        cost_wdata = r_d;
        rd_addr    = r_taddr;
        dq_cmd     = '0;
        dq_wdata   = {r_tr, r_tc};
        unique case (r_state)
            S_LOAD: begin
                if (in_acc) begin
                    wall_we = ((RW+CW+2)'(r_ld_idx) < total);
                    if (i_last_cell) begin
                        dq_cmd.clear = 1'b1;
                        n_state      = S_CLEAR;
                    end
                end
            end
            S_CLEAR: begin
                cost_we    = 1'b1;
                cost_waddr = r_clr;
                cost_wdata = COST_NONE;
                if (r_clr == AW'(CELLS-1)) begin
                    n_state = S_SEED;
                end
            end
            S_SEED: begin
                cost_waddr = lin;
                cost_wdata = '0;
                cost_we    = start_ok;
                dq_wdata   = {RW'(r_start_row), CW'(r_start_col)};
                dq_cmd.push_back = start_ok;
                n_state    = S_POP;
            end
            S_POP: begin
                if (dq_stat.empty) begin
                    n_state = S_GOAL;
                end else begin
                    dq_cmd.pop = 1'b1;
                    n_state    = S_CADR;
                end
            end
            S_CADR: begin
                rd_addr = lin;
                n_state = S_CEV;
            end
            S_CEV: begin
                n_state = (cost_rd >= COST_NONE) ? S_POP : S_TADR;
            end
            S_TADR: begin
                rd_addr = lin;
                // Skip all kicks when one more kick would saturate
                if (r_tgt >= TGT_W'(NUM_ZERO) && r_d >= COST_NONE - 1'b1) begin
                    n_state = S_POP;
                end else begin
                    n_state = S_TEV;
                end
            end
            S_TEV: begin
                if (r_tin) begin
                    if (r_tgt < TGT_W'(NUM_ZERO)) begin
                        if (!wall_rd && cost_rd > r_d) begin
                            cost_we           = 1'b1;
                            dq_cmd.push_front = 1'b1;
                        end
                    end else if (cost_rd > r_d + 1'b1) begin
                        cost_we          = 1'b1;
                        cost_wdata       = r_d + 1'b1;
                        dq_cmd.push_back = 1'b1;
                    end
                end
                n_state = (r_tgt == TGT_W'(NUM_TGT-1)) ? S_POP : S_TADR;
            end
            S_GOAL: begin
                rd_addr = lin;
                n_state = S_GRD;
            end
            S_GRD: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid) begin
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_ld_idx <= '0;
            r_clr    <= '0;
            r_tgt    <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_LOAD && in_acc) begin
                // Hold the count once the grid is full; restart after the last cell
                if (i_last_cell) begin
                    r_ld_idx <= '0;
                end else if ((RW+CW+2)'(r_ld_idx) < total) begin
                    r_ld_idx <= r_ld_idx + 1'b1;
                end
            end
            if (r_state == S_CLEAR) begin
                r_clr <= (r_clr == AW'(CELLS-1)) ? '0 : r_clr + 1'b1;
            end
            if (r_state == S_CEV) begin
                r_tgt <= '0;
            end else if (r_state == S_TEV) begin
                r_tgt <= r_tgt + 1'b1;
            end
        end
    end

    // Search datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_CADR) begin
            r_cur_r <= dq_rdata[EW-1:CW];
            r_cur_c <= dq_rdata[CW-1:0];
        end
        if (r_state == S_CEV) begin
            r_d <= cost_rd;
        end
        if (r_state == S_TADR) begin
            r_tin   <= t_ok;
            r_taddr <= lin;
            r_tr    <= tr_s[RW-1:0];
            r_tc    <= tc_s[CW-1:0];
        end
        if (r_state == S_GOAL) begin
            r_gin <= goal_ok;
        end
        if (r_state == S_GRD) begin
            r_res <= r_gin ? cost_rd : COST_NONE;
        end
    end

    // Output register: load when the search ends, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && !r_out_valid) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && !r_out_valid) begin
            r_kick_count <= r_res;
        end
    end

    gksp_grid_mem #(
        .CELLS (CELLS),
        .AW    (AW)
    ) u_grid_mem (
        .i_clk        (i_clk),
        .i_wall_we    (wall_we),
        .i_wall_waddr (AW'(r_ld_idx)),
        .i_wall_wdata (i_is_wall),
        .i_cost_we    (cost_we),
        .i_cost_waddr (cost_waddr),
        .i_cost_wdata (cost_wdata),
        .i_rd_addr    (rd_addr),
        .o_wall       (wall_rd),
        .o_cost       (cost_rd)
    );

    gksp_deque #(
        .DEPTH (DEQUE_DEPTH),
        .EW    (EW)
    ) u_deque (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (dq_cmd),
        .i_wdata (dq_wdata),
        .o_rdata (dq_rdata),
        .o_stat  (dq_stat)
    );

endmodule

>>> rtl/gksp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gksp_checker
// Port-level checks of the grid kick shortest-path block.
// ----------------------------------------------------------------------------
module gksp_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input logic                            i_last_cell,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic [gksp_pkg::COST_W-1:0]     o_kick_count,
    input logic                            i_cfg_we
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_kick_count))
        else $error("result changed while stalled");

    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_last_cell |=> o_in_stall)
        else $error("input not held off after the last cell");

    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_last_cell |=> !$rose(o_out_valid))
        else $error("result appeared without a search");

    // Register writes are to come only while the block sits idle; the block does not enforce it, this check flags it
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |-> !o_in_stall && !o_out_valid)
        else $error("configuration written while busy");

endmodule

bind grid_kick_shortest_path gksp_checker u_gksp_checker (.*);

>>> tb/sv/tb_grid_kick_shortest_path.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_kick_shortest_path
// Self-checking testbench for the grid kick shortest-path block.
// ----------------------------------------------------------------------------
// Grids of random walls go in one cell per transaction. Each accepted cell
// updates a local wall map; the cell that closes a grid runs a local 0-1
// search, and the kick count it gives is queued. The monitor compares every
// result transaction with the oldest queued kick count. Phases change the
// grid size, start and goal, and the sender and receiver idle patterns.
// ----------------------------------------------------------------------------
module tb_grid_kick_shortest_path;
    import gksp_pkg::*;

    localparam int GRID_MAX   = 32;
    localparam int CELL_MAX   = GRID_MAX * GRID_MAX;
    localparam int QUEUE_LEN  = 4096;
    localparam int CYCLE_STOP = 5000000;

    typedef struct packed {
        logic wall;
        logic last;
    } t_cell;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic              i_is_wall = 1'b0;
    logic              i_last_cell = 1'b0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [COST_W-1:0] o_kick_count;
    logic              i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = REG_GRID_ROWS;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    grid_kick_shortest_path DUT (.*);

    always #6 i_clk = ~i_clk;

    // Configuration as the block should hold it
    logic [5:0] cfg_rows = 6'd32, cfg_cols = 6'd32;
    logic [4:0] cfg_srow = '0, cfg_scol = '0, cfg_grow = '0, cfg_gcol = '0;

    // Local copy of the block state
    logic        wall_map [CELL_MAX];
    logic [9:0]  best_cost [CELL_MAX];
    int          work_q [QUEUE_LEN];
    int          load_idx = 0;

    // Stimulus bookkeeping
    t_cell       pending_cells [$];
    logic [9:0]  expected_kicks [$];
    bit          gen_written [CELL_MAX];
    int          send_idle_pct = 0, recv_stall_pct = 0;
    bit          hold_recv = 1'b0;
    int          errors = 0, results_seen = 0, cells_sent = 0, grids_sent = 0;
    int          cycle_cnt = 0;

    function automatic int eff_dim(logic [5:0] v);
        if (v == 0) return 1;
        return (v > GRID_MAX) ? GRID_MAX : int'(v);
    endfunction

    // 0-1 search over the local wall map: free steps to the front, kicks to the back
    function automatic logic [9:0] min_kicks();
        int rows, cols, head, tail, cnt, cur, r, c, nr, nc, t;
        logic [9:0] d, dk;
        int dr [4] = '{-1, 0, 1, 0};
        int dc [4] = '{0, 1, 0, -1};
        rows = eff_dim(cfg_rows);
        cols = eff_dim(cfg_cols);
        head = 0; tail = 0; cnt = 0;
        for (int i = 0; i < CELL_MAX; i++) best_cost[i] = COST_NONE;
        if (cfg_srow < rows && cfg_scol < cols) begin
            cur = cfg_srow * cols + cfg_scol;
            best_cost[cur] = '0;
            work_q[tail] = cur; tail = (tail + 1) % QUEUE_LEN; cnt++;
        end
        while (cnt > 0) begin
            cur = work_q[head];
            head = (head + 1) % QUEUE_LEN;
            cnt--;
            if (cur >= rows * cols) continue;
            d = best_cost[cur];
            if (d >= COST_NONE) continue;
            dk = d + 10'd1;
            r = cur / cols;
            c = cur % cols;
            for (int k = 0; k < 4; k++) begin
                nr = r + dr[k]; nc = c + dc[k];
                if (nr >= 0 && nr < rows && nc >= 0 && nc < cols) begin
                    t = nr * cols + nc;
                    if (!wall_map[t] && best_cost[t] > d && cnt < QUEUE_LEN) begin
                        best_cost[t] = d;
                        head = (head + QUEUE_LEN - 1) % QUEUE_LEN;
                        work_q[head] = t; cnt++;
                    end
                end
            end
            if (dk >= COST_NONE) continue;
            for (int k = 0; k < 4; k++) begin
                for (int n = 1; n <= 2; n++) begin
                    nr = r + n * dr[k]; nc = c + n * dc[k];
                    if (nr >= 0 && nr < rows && nc >= 0 && nc < cols) begin
                        t = nr * cols + nc;
                        if (best_cost[t] > dk && cnt < QUEUE_LEN) begin
                            best_cost[t] = dk;
                            work_q[tail] = t; tail = (tail + 1) % QUEUE_LEN; cnt++;
                        end
                    end
                end
            end
        end
        if (cfg_grow < rows && cfg_gcol < cols) return best_cost[cfg_grow * cols + cfg_gcol];
        return COST_NONE;
    endfunction

    // Apply one accepted cell to the local state
    task automatic load_cell(logic wall, logic last);
        if (load_idx < eff_dim(cfg_rows) * eff_dim(cfg_cols)) begin
            wall_map[load_idx] = wall;
            load_idx++;
        end
        if (last) begin
            expected_kicks.push_back(min_kicks());
            load_idx = 0;
        end
    endtask

    // Driver: advance to the next cell only when the current one is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) load_cell(i_is_wall, i_last_cell);
            if (!i_in_valid || !o_in_stall) begin
                if (pending_cells.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    t_cell nxt;
                    nxt = pending_cells.pop_front();
                    i_in_valid  <= 1'b1;
                    i_is_wall   <= nxt.wall;
                    i_last_cell <= nxt.last;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result transaction, then pick the next stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (expected_kicks.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual kick_count %0d",
                             $time, o_kick_count);
                end else begin
                    logic [9:0] exp_k;
                    exp_k = expected_kicks.pop_front();
                    if (o_kick_count !== exp_k) begin
                        errors++;
                        $display("%0t: kick_count mismatch, expected %0d, actual %0d",
                                 $time, exp_k, o_kick_count);
                    end
                end
            end
            i_out_stall <= hold_recv || ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_STOP) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= CFG_DATA_W'(val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            REG_GRID_ROWS: cfg_rows = 6'(val);
            REG_GRID_COLS: cfg_cols = 6'(val);
            REG_START_ROW: cfg_srow = 5'(val);
            REG_START_COL: cfg_scol = 5'(val);
            REG_GOAL_ROW:  cfg_grow = 5'(val);
            REG_GOAL_COL:  cfg_gcol = 5'(val);
            default: ;
        endcase
    endtask

    task automatic set_config(int rows, int cols, int sr, int sc, int gr, int gc);
        cfg_write(REG_GRID_ROWS, rows);
        cfg_write(REG_GRID_COLS, cols);
        cfg_write(REG_START_ROW, sr);
        cfg_write(REG_START_COL, sc);
        cfg_write(REG_GOAL_ROW, gr);
        cfg_write(REG_GOAL_COL, gc);
    endtask

    // Queue one grid of n cells; the last one carries the flag
    task automatic queue_grid(int n, int wall_pct);
        int total;
        t_cell c;
        total = eff_dim(cfg_rows) * eff_dim(cfg_cols);
        for (int i = 0; i < n; i++) begin
            c.wall = ($urandom_range(99) < wall_pct);
            c.last = (i == n - 1);
            pending_cells.push_back(c);
            if (i < total) gen_written[i] = 1'b1;
        end
        cells_sent += n;
        grids_sent++;
    endtask

    // Random grid: usually exact, sometimes with surplus cells, sometimes
    // short where every missing cell still holds an earlier value
    task automatic queue_random_grid();
        int total, n, covered;
        total = eff_dim(cfg_rows) * eff_dim(cfg_cols);
        n = total;
        covered = 1;
        for (int i = 0; i < total; i++) if (!gen_written[i]) covered = 0;
        if (covered && $urandom_range(99) < 15) n = $urandom_range(total, 1);
        else if ($urandom_range(99) < 15) n = total + $urandom_range(4, 1);
        queue_grid(n, $urandom_range(60, 10));
    endtask

    // Hold until the block has drained, then let it settle
    task automatic wait_idle();
        while (pending_cells.size() > 0 || i_in_valid || expected_kicks.size() > 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic random_config();
        int rows, cols, er, ec;
        case ($urandom_range(9))
            0: begin rows = 1; cols = $urandom_range(32, 1); end
            1: begin rows = $urandom_range(32, 1); cols = 1; end
            2: begin rows = 0; cols = $urandom_range(6, 0); end
            default: begin rows = $urandom_range(6, 1); cols = $urandom_range(6, 1); end
        endcase
        er = eff_dim(6'(rows));
        ec = eff_dim(6'(cols));
        set_config(rows, cols,
                   ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(er - 1),
                   ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(ec - 1),
                   ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(er - 1),
                   ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(ec - 1));
    endtask

    task automatic set_idle_mode(int mode);
        case (mode % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
            default: begin send_idle_pct = 8; recv_stall_pct = 8; end
        endcase
    endtask

    initial begin
        int phase, phase_cells;
        t_cell c;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: single cell with a wall under the start
        set_config(1, 1, 0, 0, 0, 0);
        c.wall = 1'b1; c.last = 1'b1;
        pending_cells.push_back(c); gen_written[0] = 1'b1; cells_sent++; grids_sent++;
        wait_idle();
        // Zero rows and columns act as one cell; surplus cells are dropped
        set_config(0, 0, 0, 0, 0, 0);
        queue_grid(3, 50);
        wait_idle();
        // 2x3 walled in: the goal needs kicks
        set_config(2, 3, 0, 0, 1, 2);
        for (int i = 0; i < 6; i++) begin
            c.wall = (i != 0); c.last = (i == 5);
            pending_cells.push_back(c); gen_written[i] = 1'b1;
        end
        cells_sent += 6; grids_sent++;
        wait_idle();
        // Start off the grid: no search, goal unreached
        cfg_write(REG_START_ROW, 31);
        queue_grid(6, 30);
        wait_idle();
        // Goal off the grid, start back inside; short grid reuses old cells
        set_config(2, 3, 1, 1, 1, 31);
        queue_grid(2, 30);
        wait_idle();

        // Tall grid once, rows above the maximum clamp to it
        set_config(63, 8, 31, 7, 0, 0);
        set_idle_mode(3);
        queue_grid(GRID_MAX * 8, 35);
        wait_idle();

        // Random phases over sizes, positions and idle patterns
        phase = 0;
        while (cells_sent < 900) begin
            random_config();
            set_idle_mode(phase);
            if (phase == 5) begin
                // Long receiver hold while cells keep coming
                fork
                    begin
                        hold_recv = 1'b1;
                        repeat (6000) @(posedge i_clk);
                        hold_recv = 1'b0;
                    end
                join_none
            end
            phase_cells = 0;
            while (phase_cells < 60) begin
                int before_cnt;
                before_cnt = cells_sent;
                queue_random_grid();
                phase_cells += cells_sent - before_cnt;
            end
            wait_idle();
            phase++;
        end

        wait_idle();
        repeat (200) @(posedge i_clk);
        $display("Covered %0d grids from %0d cells over %0d phases, %0d results checked.",
                 grids_sent, cells_sent, phase, results_seen);
        if (expected_kicks.size() != 0) errors++;
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
